// ----- design/assert_macros.svh -----
// Assertion macros shared by the replay window unit RTL.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define SRTPRW_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition is followed in the next cycle by a consequence.
`define SRTPRW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/srtprw_pkg.sv -----
// Package for the SRTP index replay window unit: widths, verdict codes and types.
// No dependencies; used by all modules of the unit.
package srtprw_pkg;

   localparam int SEQ_W   = 16;
   localparam int ROC_W   = 32;
   localparam int INDEX_W = SEQ_W + ROC_W;

   localparam logic [SEQ_W-1:0] SEQ_HALF = 16'h8000;

   typedef logic [1:0] verdict_type;

   localparam verdict_type VERDICT_NEW   = 2'd0;
   localparam verdict_type VERDICT_FRESH = 2'd1;
   localparam verdict_type VERDICT_DUP   = 2'd2;
   localparam verdict_type VERDICT_OLD   = 2'd3;

   typedef struct packed {
      logic               have;
      logic [INDEX_W-1:0] highest;
   } track_type;

endpackage

// ----- design/srtprw_roc_est.sv -----
// Rollover counter estimator: forms the 48-bit packet index from a sequence number.
// Depends on srtprw_pkg for widths, the half-range constant and the tracking struct.
module srtprw_roc_est (
   input  srtprw_pkg::track_type                   track,
   input  logic                                    new_source,
   input  logic [srtprw_pkg::SEQ_W-1:0]            sequence_req,
   output logic [srtprw_pkg::INDEX_W-1:0]          packet_index
);

   logic [srtprw_pkg::ROC_W-1:0] roc;
   logic [srtprw_pkg::ROC_W-1:0] roc_guess;
   logic [srtprw_pkg::SEQ_W-1:0] hs;
   logic [srtprw_pkg::SEQ_W:0]   hs_plus_half;

   always_comb begin
      roc          = track.highest[srtprw_pkg::INDEX_W-1:srtprw_pkg::SEQ_W];
      hs           = track.highest[srtprw_pkg::SEQ_W-1:0];
      hs_plus_half = {1'b0, hs} + {1'b0, srtprw_pkg::SEQ_HALF};
      roc_guess    = roc;
      if (hs < srtprw_pkg::SEQ_HALF) begin
         if (({1'b0, sequence_req} > hs_plus_half) && (roc != '0)) begin
            roc_guess = roc - srtprw_pkg::ROC_W'(1);
         end
      end else if (sequence_req < (hs - srtprw_pkg::SEQ_HALF)) begin
         roc_guess = roc + srtprw_pkg::ROC_W'(1);
      end
      if (!track.have || new_source) begin
         packet_index = {{srtprw_pkg::ROC_W{1'b0}}, sequence_req};
      end else begin
         packet_index = {roc_guess, sequence_req};
      end
   end

endmodule

// ----- design/srtprw_window.sv -----
// Replay window: highest index, sliding seen-bitmap and the per-item verdict.
// Depends on srtprw_pkg and on assert_macros.svh for its checks.
`include "assert_macros.svh"

module srtprw_window #(
   parameter int WINDOW = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 update,
   input  logic                                 new_source,
   input  logic [srtprw_pkg::INDEX_W-1:0]       packet_index,
   output srtprw_pkg::track_type                track,
   output srtprw_pkg::verdict_type              verdict
);

   localparam int SHW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

   logic                            have_ff;
   logic                            have_in;
   logic [srtprw_pkg::INDEX_W-1:0]  highest_ff;
   logic [srtprw_pkg::INDEX_W-1:0]  highest_in;
   logic [WINDOW-1:0]               window_ff;
   logic [WINDOW-1:0]               window_in;

   logic                            have_cur;
   logic [srtprw_pkg::INDEX_W-1:0]  highest_cur;
   logic [WINDOW-1:0]               window_cur;
   logic [srtprw_pkg::INDEX_W-1:0]  advance;
   logic [srtprw_pkg::INDEX_W-1:0]  age;
   logic [WINDOW-1:0]               age_mask;

   always_comb begin
      have_cur    = have_ff && !new_source;
      highest_cur = new_source ? '0 : highest_ff;
      window_cur  = new_source ? '0 : window_ff;
      advance     = packet_index - highest_cur;
      age         = highest_cur - packet_index;
      age_mask    = WINDOW'(1) << age[SHW-1:0];
      have_in     = have_cur;
      highest_in  = highest_cur;
      window_in   = window_cur;
      if (!have_cur) begin
         have_in    = 1'b1;
         highest_in = packet_index;
         window_in  = WINDOW'(1);
         verdict    = srtprw_pkg::VERDICT_NEW;
      end else if (packet_index > highest_cur) begin
         highest_in = packet_index;
         if (advance >= srtprw_pkg::INDEX_W'(WINDOW)) begin
            window_in = WINDOW'(1);
         end else begin
            window_in = (window_cur << advance[SHW-1:0]) | WINDOW'(1);
         end
         verdict = srtprw_pkg::VERDICT_NEW;
      end else if (age >= srtprw_pkg::INDEX_W'(WINDOW)) begin
         verdict = srtprw_pkg::VERDICT_OLD;
      end else if ((window_cur & age_mask) != '0) begin
         verdict = srtprw_pkg::VERDICT_DUP;
      end else begin
         window_in = window_cur | age_mask;
         verdict   = srtprw_pkg::VERDICT_FRESH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff    <= 1'b0;
         highest_ff <= '0;
         window_ff  <= '0;
      end else if (update) begin
         have_ff    <= have_in;
         highest_ff <= highest_in;
         window_ff  <= window_in;
      end
   end

   assign track.have    = have_ff;
   assign track.highest = highest_ff;

   `SRTPRW_ASSERT(a_highest_marked, clock, reset, !have_ff || window_ff[0], "highest index not marked as seen")
   `SRTPRW_ASSERT_NEXT(a_new_moves_highest, clock, reset, update && (verdict == srtprw_pkg::VERDICT_NEW), have_ff && (highest_ff == $past(packet_index)), "new highest not stored")
   `SRTPRW_ASSERT_NEXT(a_reject_keeps_state, clock, reset, update && !new_source && ((verdict == srtprw_pkg::VERDICT_DUP) || (verdict == srtprw_pkg::VERDICT_OLD)), $stable(highest_ff) && $stable(window_ff), "rejected item changed the window")

endmodule

// ----- design/srtp_index_replay_window_unit.sv -----
// SRTP index replay window unit, top level.
// Uses srtprw_pkg, srtprw_roc_est, srtprw_window and assert_macros.svh.
//
// The req channel carries one item per authenticated packet: its 16-bit
// sequence number and a new_source flag that clears all index and window
// state before the packet is handled. The rsp channel returns one item per
// request: accepted, the estimated 48-bit packet index and a 2-bit verdict
// (new highest, fresh inside the window, duplicate, too old).
// An accepted request is held in an input register; once the output register
// is free, the index estimate and the window check run in one pass and the
// result lands in the output register, from which it is offered.
// One item per cycle is sustained while rsp_stall stays low; the limit is the
// path of the 48-bit compare and the bitmap shift between the input
// register and the window state.
// When rsp_stall holds a waiting result, the item in the input register waits
// and req_stall rises; no item is lost or repeated. Synchronous reset empties
// both registers and clears the window state, as for a new source.
`include "assert_macros.svh"

module srtp_index_replay_window_unit #(
   parameter int WINDOW = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [srtprw_pkg::SEQ_W-1:0]         req_sequence_req,
   input  logic                                 req_new_source,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_accepted,
   output logic [srtprw_pkg::INDEX_W-1:0]       rsp_packet_index,
   output logic [1:0]                           rsp_verdict
);

   logic                            s1_valid_ff;
   logic                            s1_valid_in;
   logic [srtprw_pkg::SEQ_W-1:0]    s1_seq_ff;
   logic                            s1_new_ff;
   logic                            out_valid_ff;
   logic                            out_valid_in;
   logic                            out_accepted_ff;
   logic [srtprw_pkg::INDEX_W-1:0]  out_index_ff;
   srtprw_pkg::verdict_type         out_verdict_ff;

   logic                            out_free;
   logic                            advance;
   logic                            take_req;
   srtprw_pkg::track_type           track;
   srtprw_pkg::verdict_type         verdict;
   logic [srtprw_pkg::INDEX_W-1:0]  packet_index;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign take_req  = req_valid && !req_stall;

   assign s1_valid_in  = take_req || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   srtprw_roc_est u_roc_est (
      .track        (track),
      .new_source   (s1_new_ff),
      .sequence_req (s1_seq_ff),
      .packet_index (packet_index)
   );

   srtprw_window #(
      .WINDOW (WINDOW)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .update       (advance),
      .new_source   (s1_new_ff),
      .packet_index (packet_index),
      .track        (track),
      .verdict      (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         s1_seq_ff <= req_sequence_req;
         s1_new_ff <= req_new_source;
      end
      if (advance) begin
         out_accepted_ff <= (verdict == srtprw_pkg::VERDICT_NEW) ||
                            (verdict == srtprw_pkg::VERDICT_FRESH);
         out_index_ff    <= packet_index;
         out_verdict_ff  <= verdict;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_accepted     = out_accepted_ff;
   assign rsp_packet_index = out_index_ff;
   assign rsp_verdict      = out_verdict_ff;

   `SRTPRW_ASSERT_NEXT(a_advance_fills_out, clock, reset, advance, out_valid_ff, "processed item did not reach the output register")
   `SRTPRW_ASSERT(a_stall_only_when_busy, clock, reset, !req_stall || (s1_valid_ff && out_valid_ff), "input stalled while a stage was free")
   `SRTPRW_ASSERT_NEXT(a_verdict_matches_accept, clock, reset, advance, rsp_accepted == ((rsp_verdict == srtprw_pkg::VERDICT_NEW) || (rsp_verdict == srtprw_pkg::VERDICT_FRESH)), "accepted flag disagrees with verdict")

endmodule

// ----- tb/srtp_index_replay_window_checker.sv -----
// Checker for the SRTP index replay window unit: predicts each result item from
// the request items it sees and compares every taken result field by field.
// Depends on srtprw_pkg for widths and verdict codes.
module srtp_index_replay_window_checker #(
   parameter int WINDOW = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [srtprw_pkg::SEQ_W-1:0]       req_sequence_req,
   input  logic                               req_new_source,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic                               rsp_accepted,
   input  logic [srtprw_pkg::INDEX_W-1:0]     rsp_packet_index,
   input  logic [1:0]                         rsp_verdict,
   output int                                 fail_count,
   output int                                 outstanding
);

   localparam logic [63:0] WINDOW_MASK = (WINDOW >= 64) ? {64{1'b1}} :
                                         ((64'd1 << WINDOW) - 64'd1);

   typedef struct packed {
      logic                           accepted;
      logic [srtprw_pkg::INDEX_W-1:0] index;
      srtprw_pkg::verdict_type        verdict;
   } packet_outcome_type;

   logic                           have_highest;
   logic [srtprw_pkg::INDEX_W-1:0] top_index;
   logic [63:0]                    seen_bits;

   packet_outcome_type pending_outcomes[$];
   packet_outcome_type want;

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   function automatic packet_outcome_type track_packet(
      input logic [srtprw_pkg::SEQ_W-1:0] seq,
      input logic                         fresh_source);
      packet_outcome_type             outcome;
      logic [srtprw_pkg::ROC_W-1:0]   roc;
      logic [srtprw_pkg::SEQ_W-1:0]   high_seq;
      logic [srtprw_pkg::INDEX_W-1:0] idx;
      logic [srtprw_pkg::INDEX_W-1:0] gap;
      if (fresh_source) begin
         have_highest = 1'b0;
         top_index = '0;
         seen_bits = '0;
      end
      roc = top_index[srtprw_pkg::INDEX_W-1:srtprw_pkg::SEQ_W];
      high_seq = top_index[srtprw_pkg::SEQ_W-1:0];
      if (!have_highest) begin
         roc = '0;
      end else if (high_seq < srtprw_pkg::SEQ_HALF) begin
         if ({1'b0, seq} > {1'b0, high_seq} + {1'b0, srtprw_pkg::SEQ_HALF} && roc != '0)
            roc = roc - srtprw_pkg::ROC_W'(1);
      end else if (seq < high_seq - srtprw_pkg::SEQ_HALF) begin
         roc = roc + srtprw_pkg::ROC_W'(1);
      end
      idx = {roc, seq};
      outcome.index = idx;
      if (!have_highest) begin
         have_highest = 1'b1;
         top_index = idx;
         seen_bits = 64'd1;
         outcome.verdict = srtprw_pkg::VERDICT_NEW;
      end else if (idx > top_index) begin
         gap = idx - top_index;
         if (gap >= srtprw_pkg::INDEX_W'(WINDOW))
            seen_bits = 64'd1;
         else
            seen_bits = ((seen_bits << gap) | 64'd1) & WINDOW_MASK;
         top_index = idx;
         outcome.verdict = srtprw_pkg::VERDICT_NEW;
      end else begin
         gap = top_index - idx;
         if (gap >= srtprw_pkg::INDEX_W'(WINDOW)) begin
            outcome.verdict = srtprw_pkg::VERDICT_OLD;
         end else if (seen_bits[gap[5:0]]) begin
            outcome.verdict = srtprw_pkg::VERDICT_DUP;
         end else begin
            seen_bits[gap[5:0]] = 1'b1;
            outcome.verdict = srtprw_pkg::VERDICT_FRESH;
         end
      end
      outcome.accepted = (outcome.verdict == srtprw_pkg::VERDICT_NEW) ||
                         (outcome.verdict == srtprw_pkg::VERDICT_FRESH);
      return outcome;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         have_highest = 1'b0;
         top_index = '0;
         seen_bits = '0;
         pending_outcomes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               fail_count = fail_count + 1;
               if (fail_count <= 10)
                  $display("%0t: unexpected item: acc %b index %h verdict %0d",
                           $time, rsp_accepted, rsp_packet_index, rsp_verdict);
            end else begin
               want = pending_outcomes[0];
               pending_outcomes.delete(0);
               if (rsp_accepted !== want.accepted || rsp_packet_index !== want.index ||
                   rsp_verdict !== want.verdict) begin
                  fail_count = fail_count + 1;
                  if (fail_count <= 10)
                     $display("%0t: mismatch: acc exp %b got %b, index exp %h got %h,",
                              $time, want.accepted, rsp_accepted, want.index,
                              rsp_packet_index,
                              " verdict exp %0d got %0d", want.verdict, rsp_verdict);
               end
            end
         end
         if (req_valid && !req_stall)
            pending_outcomes.push_back(track_packet(req_sequence_req, req_new_source));
      end
      outstanding = pending_outcomes.size();
   end

endmodule

// ----- tb/srtp_index_replay_window_unit_tb.sv -----
// Testbench top for the SRTP index replay window unit: clock, reset, request
// stimulus and random result stalls, with the verdict taken from the checker.
// Depends on srtprw_pkg, the unit and srtp_index_replay_window_checker.
module srtp_index_replay_window_unit_tb;

   localparam int PACKETS_PER_PHASE = 280;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   logic [srtprw_pkg::SEQ_W-1:0]       req_sequence_req = '0;
   logic                               req_new_source = 1'b0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   logic                               rsp_accepted;
   logic [srtprw_pkg::INDEX_W-1:0]     rsp_packet_index;
   logic [1:0]                         rsp_verdict;

   int fail_count;
   int outstanding;
   int send_idle_pct = 34;
   int recv_stall_pct = 76;
   logic [15:0] last_seq;

   srtp_index_replay_window_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sequence_req (req_sequence_req),
      .req_new_source   (req_new_source),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_packet_index (rsp_packet_index),
      .rsp_verdict      (rsp_verdict)
   );

   srtp_index_replay_window_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sequence_req (req_sequence_req),
      .req_new_source   (req_new_source),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_accepted     (rsp_accepted),
      .rsp_packet_index (rsp_packet_index),
      .rsp_verdict      (rsp_verdict),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic send_packet(input logic [15:0] seq, input logic fresh_source);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sequence_req <= seq;
      req_new_source <= fresh_source;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random_packet();
      int          pick;
      logic [15:0] seq;
      pick = $urandom_range(99);
      if (pick < 55) begin
         seq = last_seq + 16'($urandom_range(1, 4));
         last_seq = seq;
      end else if (pick < 70) begin
         seq = last_seq - 16'($urandom_range(0, 70));
      end else if (pick < 78) begin
         seq = last_seq + 16'($urandom_range(5, 200));
         last_seq = seq;
      end else if (pick < 84) begin
         seq = last_seq + 16'($urandom_range(16'h7F00, 16'h80FF));
         last_seq = seq;
      end else if (pick < 90) begin
         seq = last_seq - 16'($urandom_range(16'h7F00, 16'h8100));
      end else if (pick < 96) begin
         seq = 16'($urandom);
      end else begin
         seq = last_seq;
      end
      send_packet(seq, $urandom_range(99) < 2);
   endtask

   initial begin
      last_seq = 16'($urandom);
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_packet(16'h0000, 1'b1);
      send_packet(16'h0000, 1'b0);
      send_packet(16'hFFFF, 1'b0);
      send_packet(16'h0000, 1'b0);
      send_packet(16'hFFFE, 1'b0);
      send_packet(16'hFFFE, 1'b0);
      send_packet(16'hFF00, 1'b0);
      send_packet(16'h0005, 1'b0);
      send_packet(16'h0003, 1'b0);
      send_packet(16'h0040, 1'b0);
      send_packet(16'h0001, 1'b0);
      send_packet(16'h0000, 1'b0);
      send_packet(16'h7FFF, 1'b0);
      send_packet(16'hAAAA, 1'b0);
      send_packet(16'h5555, 1'b0);
      send_packet(16'hFFFF, 1'b1);
      send_packet(16'h7FFF, 1'b0);
      send_packet(16'h7FFE, 1'b0);
      send_packet(16'h1234, 1'b1);
      send_packet(16'h9235, 1'b0);
      send_packet(16'h9234, 1'b0);
      send_packet(16'h9235, 1'b1);
      send_packet(16'h9235, 1'b0);

      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 1) begin
            send_idle_pct = 76;
            recv_stall_pct = 34;
         end else if (phase == 2) begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         for (int n = 0; n < PACKETS_PER_PHASE; n++)
            send_random_packet();
         req_valid <= 1'b0;
         @(negedge clock);
         while (outstanding != 0) @(negedge clock);
      end

      repeat (8) @(negedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
